// ===== rtl/isr_pkg.sv =====
package isr_pkg;

    localparam int MAX_RANGES_DEF = 64;
    localparam int SPAN_W         = 32;
    localparam int CHG_W          = 33;

    localparam logic [1:0] OP_CONTAINS = 2'd0;
    localparam logic [1:0] OP_SET      = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [SPAN_W-1:0] first_start;
        logic [SPAN_W-1:0] last_end;
        logic [CHG_W-1:0]  total;
        logic              hit;
    } scan_sum_t;

    function automatic logic [CHG_W-1:0] negate(input logic [SPAN_W-1:0] v);
        return ~{1'b0, v} + CHG_W'(1);
    endfunction

endpackage

// ===== rtl/isr_ram.sv =====
module isr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/isr_scan.sv =====
module isr_scan #(
    parameter int MAX_RANGES = isr_pkg::MAX_RANGES_DEF,
    localparam int CW = $clog2(MAX_RANGES + 1)
) (
    input  logic                      aclk,
    input  logic                      clr,
    input  logic                      en,
    input  logic [1:0]                op,
    input  logic [isr_pkg::SPAN_W-1:0] span_low,
    input  logic [isr_pkg::SPAN_W-1:0] span_high,
    input  logic [isr_pkg::SPAN_W-1:0] query_point,
    input  logic [isr_pkg::SPAN_W-1:0] ent_start,
    input  logic [isr_pkg::SPAN_W-1:0] ent_end,
    output logic [CW-1:0]             first_idx,
    output logic [CW-1:0]             hit_count,
    output isr_pkg::scan_sum_t        sum
);
    import isr_pkg::*;

    logic [CW-1:0]     f_reg, n_reg;
    scan_sum_t         sum_reg;
    logic              is_set, ahead, aff;
    logic [SPAN_W-1:0] ov_hi, ov_lo, len;

    always_comb begin
        is_set = (op == OP_SET);
        ahead  = is_set ? (ent_end < span_low) : (ent_end <= span_low);
        aff    = is_set ? (ent_end >= span_low && ent_start <= span_high)
                        : (ent_end > span_low && ent_start < span_high);
        ov_hi  = (ent_end < span_high) ? ent_end : span_high;
        ov_lo  = (ent_start > span_low) ? ent_start : span_low;
        len    = is_set ? (ent_end - ent_start) : (ov_hi - ov_lo);
    end

    always_ff @(posedge aclk) begin
        if (clr) begin
            f_reg   <= '0;
            n_reg   <= '0;
            sum_reg <= '0;
        end else if (en) begin
            if (op == OP_CONTAINS) begin
                if (ent_start <= query_point && query_point < ent_end) begin
                    sum_reg.hit <= 1'b1;
                end
            end else begin
                if (ahead) begin
                    f_reg <= f_reg + CW'(1);
                end
                if (aff) begin
                    if (n_reg == '0) begin
                        sum_reg.first_start <= ent_start;
                    end
                    n_reg            <= n_reg + CW'(1);
                    sum_reg.last_end <= ent_end;
                    sum_reg.total    <= sum_reg.total + {1'b0, len};
                end
            end
        end
    end

    assign first_idx = f_reg;
    assign hit_count = n_reg;
    assign sum       = sum_reg;
endmodule

// ===== rtl/interval_set_tracker.sv =====
// Channel   Dir  tdata                                   tuser
// s_        in   span_low, span_high, query_point        operation, apply_change
// m_        out  is_covered, covered_change              status
//
// Prefix-form requests are resolved on acceptance and then wait for the output,
// unless an applied change must first move the prefix into the range table.
// Table-form requests scan every stored range; applied changes then shift the
// tail entries and write the new pieces. Scan and shift share the RAMs' read port.
// Reset (aresetn low, synchronous) empties the set; the RAMs need no clearing.
// A finished result is held in the output register until m_tready.
module interval_set_tracker #(
    parameter int MAX_RANGES = isr_pkg::MAX_RANGES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // span_low[31:0], span_high[63:32], query_point[95:64]
    input  logic [2:0]  s_tuser,   // operation[1:0], apply_change[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // is_covered[0], covered_change[33:1], zero[39:34]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import isr_pkg::*;

    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LEAVE  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_PIECE  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [1:0]        in_op;
    logic [SPAN_W-1:0] in_lo, in_hi, in_q;
    logic              in_apply;

    assign in_op    = s_tuser[1:0];
    assign in_apply = s_tuser[2];
    assign in_lo    = s_tdata[31:0];
    assign in_hi    = s_tdata[63:32];
    assign in_q     = s_tdata[95:64];

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [SPAN_W-1:0] prefix_reg, prefix_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              dv_reg, dv_next;

    logic [1:0]        op_reg, op_next;
    logic [SPAN_W-1:0] lo_reg, lo_next, hi_reg, hi_next, q_reg, q_next;
    logic              apply_reg, apply_next;
    logic [1:0]        stat_reg, stat_next;
    logic              cov_reg, cov_next;
    logic [CHG_W-1:0]  chg_reg, chg_next;
    logic [1:0]        m_status_reg;
    logic              m_cov_reg;
    logic [CHG_W-1:0]  m_chg_reg;
    logic [CW-1:0]     rd_k_reg, rd_k_next, rem_reg, rem_next, src_reg, src_next;
    logic [CW-1:0]     dist_reg, dist_next, f_reg, f_next, newcnt_reg, newcnt_next;
    logic              up_reg, up_next;
    logic [1:0]        pc_reg, pc_next, pi_reg, pi_next;
    logic [SPAN_W-1:0] ps_reg [2];
    logic [SPAN_W-1:0] pe_reg [2];
    logic [SPAN_W-1:0] ps_next [2];
    logic [SPAN_W-1:0] pe_next [2];

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [SPAN_W-1:0] ram_wstart, ram_wend, ram_rstart, ram_rend;
    logic              scan_clr, scan_en, out_load, issue;
    logic [CW-1:0]     scan_f, scan_n, t0, m_cw, wa;
    scan_sum_t         scan_sum;
    logic [SPAN_W-1:0] nf, nt;
    logic              lp, rp, full;
    logic [1:0]        m_pc;

    isr_ram #(.WIDTH(SPAN_W), .DEPTH(MAX_RANGES)) u_start_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wstart),
        .raddr(ram_raddr), .rdata(ram_rstart)
    );

    isr_ram #(.WIDTH(SPAN_W), .DEPTH(MAX_RANGES)) u_end_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wend),
        .raddr(ram_raddr), .rdata(ram_rend)
    );

    isr_scan #(.MAX_RANGES(MAX_RANGES)) u_scan (
        .aclk(aclk), .clr(scan_clr), .en(scan_en), .op(op_reg),
        .span_low(lo_reg), .span_high(hi_reg), .query_point(q_reg),
        .ent_start(ram_rstart), .ent_end(ram_rend),
        .first_idx(scan_f), .hit_count(scan_n), .sum(scan_sum)
    );

    always_comb begin
        nf = (scan_n != '0 && scan_sum.first_start < lo_reg) ? scan_sum.first_start : lo_reg;
        nt = (scan_n != '0 && scan_sum.last_end > hi_reg) ? scan_sum.last_end : hi_reg;
        lp = (scan_n != '0) && (scan_sum.first_start < lo_reg);
        rp = (scan_n != '0) && (scan_sum.last_end > hi_reg);
        if (op_reg == OP_SET) begin
            m_pc = 2'd1;
            full = (scan_n == '0) && (count_reg == CW'(MAX_RANGES));
        end else begin
            m_pc = {1'b0, lp} + {1'b0, rp};
            full = (scan_n == CW'(1)) && lp && rp && (count_reg == CW'(MAX_RANGES));
        end
        m_cw = CW'(m_pc);
        t0   = scan_f + scan_n;
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        prefix_next   = prefix_reg;
        m_tvalid_next = m_tvalid_reg;
        dv_next       = dv_reg;
        op_next       = op_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        q_next        = q_reg;
        apply_next    = apply_reg;
        stat_next     = stat_reg;
        cov_next      = cov_reg;
        chg_next      = chg_reg;
        rd_k_next     = rd_k_reg;
        rem_next      = rem_reg;
        src_next      = src_reg;
        dist_next     = dist_reg;
        f_next        = f_reg;
        newcnt_next   = newcnt_reg;
        up_next       = up_reg;
        pc_next       = pc_reg;
        pi_next       = pi_reg;
        ps_next       = ps_reg;
        pe_next       = pe_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wstart    = '0;
        ram_wend      = '0;
        ram_raddr     = rd_k_reg[AW-1:0];
        scan_clr      = 1'b0;
        scan_en       = 1'b0;
        s_tready      = 1'b0;
        out_load      = 1'b0;
        issue         = 1'b0;
        wa            = '0;

        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next    = in_op;
                    lo_next    = in_lo;
                    hi_next    = in_hi;
                    q_next     = in_q;
                    apply_next = in_apply;
                    scan_clr   = 1'b1;
                    rd_k_next  = '0;
                    dv_next    = 1'b0;
                    stat_next  = ST_OK;
                    cov_next   = 1'b0;
                    chg_next   = '0;
                    case (in_op)
                        OP_CONTAINS: begin
                            if (count_reg == '0) begin
                                cov_next   = (in_q < prefix_reg);
                                state_next = S_DONE;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_SET, OP_CLEAR: begin
                            if (in_hi <= in_lo) begin
                                stat_next  = ST_INVALID;
                                state_next = S_DONE;
                            end else if (count_reg != '0) begin
                                state_next = S_SCAN;
                            end else if (in_op == OP_SET) begin
                                if (in_lo >= prefix_reg) begin
                                    chg_next = {1'b0, in_hi - in_lo};
                                end else if (in_hi >= prefix_reg) begin
                                    chg_next = {1'b0, in_hi - prefix_reg};
                                end
                                if (in_apply && in_lo > prefix_reg) begin
                                    state_next = (prefix_reg != '0) ? S_LEAVE : S_SCAN;
                                end else begin
                                    if (in_apply && in_hi > prefix_reg) begin
                                        prefix_next = in_hi;
                                    end
                                    state_next = S_DONE;
                                end
                            end else begin
                                if (in_lo >= prefix_reg) begin
                                    state_next = S_DONE;
                                end else if (in_hi >= prefix_reg) begin
                                    chg_next = negate(prefix_reg - in_lo);
                                    if (in_apply) begin
                                        prefix_next = in_lo;
                                    end
                                    state_next = S_DONE;
                                end else if (!in_apply) begin
                                    chg_next   = negate(in_hi - in_lo);
                                    state_next = S_DONE;
                                end else begin
                                    state_next = S_LEAVE;
                                end
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_LEAVE: begin
                ram_we      = 1'b1;
                ram_waddr   = '0;
                ram_wstart  = '0;
                ram_wend    = prefix_reg;
                count_next  = CW'(1);
                prefix_next = '0;
                state_next  = S_SCAN;
            end
            S_SCAN: begin
                issue   = (rd_k_reg < count_reg);
                if (issue) begin
                    rd_k_next = rd_k_reg + CW'(1);
                end
                dv_next = issue;
                scan_en = dv_reg;
                if (!issue && !dv_reg) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next = S_DONE;
                if (op_reg == OP_CONTAINS) begin
                    cov_next = scan_sum.hit;
                end else if (full) begin
                    stat_next = ST_FULL;
                    chg_next  = '0;
                end else begin
                    if (op_reg == OP_SET) begin
                        chg_next   = {1'b0, nt - nf} - scan_sum.total;
                        ps_next[0] = nf;
                        pe_next[0] = nt;
                    end else begin
                        chg_next   = ~scan_sum.total + CHG_W'(1);
                        ps_next[0] = lp ? scan_sum.first_start : hi_reg;
                        pe_next[0] = lp ? lo_reg : scan_sum.last_end;
                        ps_next[1] = hi_reg;
                        pe_next[1] = scan_sum.last_end;
                    end
                    if (apply_reg) begin
                        f_next      = scan_f;
                        pc_next     = m_pc;
                        pi_next     = '0;
                        newcnt_next = count_reg + m_cw - scan_n;
                        dv_next     = 1'b0;
                        rem_next    = (m_cw == scan_n) ? '0 : count_reg - t0;
                        up_next     = (m_cw > scan_n);
                        dist_next   = scan_n - m_cw;
                        rd_k_next   = (m_cw > scan_n) ? count_reg - CW'(1) : t0;
                        state_next  = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                issue = (rem_reg != '0);
                if (issue) begin
                    rem_next  = rem_reg - CW'(1);
                    rd_k_next = up_reg ? rd_k_reg - CW'(1) : rd_k_reg + CW'(1);
                    src_next  = rd_k_reg;
                end
                dv_next = issue;
                if (dv_reg) begin
                    wa         = up_reg ? src_reg + CW'(1) : src_reg - dist_reg;
                    ram_we     = 1'b1;
                    ram_waddr  = wa[AW-1:0];
                    ram_wstart = ram_rstart;
                    ram_wend   = ram_rend;
                end
                if (!issue && !dv_reg) begin
                    state_next = S_PIECE;
                end
            end
            S_PIECE: begin
                if (pi_reg < pc_reg) begin
                    wa         = f_reg + CW'(pi_reg);
                    ram_we     = 1'b1;
                    ram_waddr  = wa[AW-1:0];
                    ram_wstart = ps_reg[pi_reg[0]];
                    ram_wend   = pe_reg[pi_reg[0]];
                    pi_next    = pi_reg + 2'd1;
                end else begin
                    count_next = newcnt_reg;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            prefix_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            dv_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            prefix_reg   <= prefix_next;
            m_tvalid_reg <= m_tvalid_next;
            dv_reg       <= dv_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        q_reg      <= q_next;
        apply_reg  <= apply_next;
        stat_reg   <= stat_next;
        cov_reg    <= cov_next;
        chg_reg    <= chg_next;
        rd_k_reg   <= rd_k_next;
        rem_reg    <= rem_next;
        src_reg    <= src_next;
        dist_reg   <= dist_next;
        f_reg      <= f_next;
        newcnt_reg <= newcnt_next;
        up_reg     <= up_next;
        pc_reg     <= pc_next;
        pi_reg     <= pi_next;
        ps_reg     <= ps_next;
        pe_reg     <= pe_next;
        if (out_load) begin
            m_status_reg <= stat_reg;
            m_cov_reg    <= cov_reg;
            m_chg_reg    <= chg_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {6'b0, m_chg_reg, m_cov_reg};

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_RANGES))
        else $error("range count above capacity");

    a_prefix_form: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != '0 |-> prefix_reg == '0)
        else $error("prefix and range table both in use");

    a_scan_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> !ram_we)
        else $error("table write during scan");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");
`endif
endmodule
